/* src/crf_pkg.sv */
// ----------------------------------------------------------------------------
// crf_pkg
// Types, codes and helpers shared by the connection retry state machine.
// ----------------------------------------------------------------------------
package crf_pkg;

    // one-hot state register codes
    typedef enum logic [5:0] {
        ST_HALTED     = 6'b000001,
        ST_INIT       = 6'b000010,
        ST_CONNECTING = 6'b000100,
        ST_TIMEOUT    = 6'b001000,
        ST_CONNECTED  = 6'b010000,
        ST_FAILED     = 6'b100000
    } state_t;

    // link state codes as reported on the result stream
    localparam logic [2:0] LINK_HALTED     = 3'd0;
    localparam logic [2:0] LINK_INIT       = 3'd1;
    localparam logic [2:0] LINK_CONNECTING = 3'd2;
    localparam logic [2:0] LINK_TIMEOUT    = 3'd3;
    localparam logic [2:0] LINK_CONNECTED  = 3'd4;
    localparam logic [2:0] LINK_FAILED     = 3'd5;

    // event codes
    localparam logic [2:0] REQ_START      = 3'd0;
    localparam logic [2:0] REQ_RECONNECT  = 3'd1;
    localparam logic [2:0] REQ_INIT_REPLY = 3'd2;
    localparam logic [2:0] REQ_OPEN_REPLY = 3'd3;
    localparam logic [2:0] REQ_LINK_ERROR = 3'd4;
    localparam logic [2:0] REQ_TICK       = 3'd5;
    localparam logic [2:0] REQ_HOOK       = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_CONNECT_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_RETRY_DELAY     = 2'd1;
    localparam logic [1:0] CFG_HOOK_ENABLE     = 2'd2;

    localparam logic [15:0] CONNECT_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] RETRY_DELAY_RST     = 16'd1000;

    typedef struct packed {
        logic       event_ignored;
        logic [2:0] fail_cause;
        logic       ask_hook;
        logic       request_close;
        logic       request_init;
        logic [2:0] link_state;
    } result_t;

    function automatic logic [2:0] state_code(input state_t st);
        logic [2:0] code;
        case (st)
            ST_HALTED:     code = LINK_HALTED;
            ST_INIT:       code = LINK_INIT;
            ST_CONNECTING: code = LINK_CONNECTING;
            ST_TIMEOUT:    code = LINK_TIMEOUT;
            ST_CONNECTED:  code = LINK_CONNECTED;
            ST_FAILED:     code = LINK_FAILED;
            default:       code = LINK_HALTED;
        endcase
        return code;
    endfunction

endpackage

/* src/connection_retry_fsm.sv */
// ----------------------------------------------------------------------------
// connection_retry_fsm
// Connection manager with connect timeout, retry delay and failure hook.
// ----------------------------------------------------------------------------
// Input stream s_*: one event per transaction (event code and reply flag).
// Output stream m_*: exactly one result per event, giving the link state after
// the event, the init, close and hook request pulses, the cause of the latest
// failure and whether the event was ignored.
// Config channel cfg_*: index 0 connect timeout, 1 retry delay, 2 hook enable;
// always ready, other indexes are dropped.
// The result of an event appears on m_tvalid in the cycle after its
// transaction. Throughput: one event per cycle while results are taken; the
// state update is a single pass of logic between state and result registers.
// Reset puts the link in halted with the countdown and failure cause cleared
// and the registers at their defaults (1000, 1000, hook off).
// When the receiver stalls, the result register holds and s_tready drops until
// the pending result is taken; it stays high while the result drains.
// ----------------------------------------------------------------------------
module connection_retry_fsm #(
    parameter int TIMER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [2:0] req_type, [3] reply_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [2:0] link_state, [3] request_init,
                                     // [4] request_close, [5] ask_hook,
                                     // [8:6] fail_cause, [9] event_ignored
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LOAD_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [LOAD_BITS-1:0] TIMER_MAX = LOAD_BITS'({TIMER_BITS{1'b1}});

    logic [15:0] connect_timeout_reg;
    logic [15:0] retry_delay_reg;
    logic        hook_enable_reg;

    crf_pkg::state_t         state_reg, state_next;
    logic [2:0]              origin_reg, origin_next;
    logic [TIMER_BITS-1:0]   count_reg, count_next;
    logic                    await_reg, await_next;

    crf_pkg::result_t        result_reg, result_next;
    logic                    out_valid_reg;

    logic [2:0] req_type;
    logic       reply_ok;
    logic       in_fire;
    logic       expired;
    logic       do_fail;
    logic       do_init;
    logic [2:0] fail_from;

    assign req_type  = s_tdata[2:0];
    assign reply_ok  = s_tdata[3];
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign expired   = (count_reg[TIMER_BITS-1:1] == '0);

    // load with saturation when the timer is narrower than the register
    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] v);
        logic [LOAD_BITS-1:0] ext;
        ext = LOAD_BITS'(v);
        return TIMER_BITS'((ext > TIMER_MAX) ? TIMER_MAX : ext);
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        origin_next = origin_reg;
        count_next  = count_reg;
        await_next  = await_reg;
        result_next = '0;
        do_fail     = 1'b0;
        do_init     = 1'b0;
        fail_from   = crf_pkg::state_code(state_reg);

        if (await_reg)
        begin
            if (req_type == crf_pkg::REQ_HOOK)
            begin
                await_next = 1'b0;
                if (reply_ok)
                begin
                    do_init = 1'b1;
                end
                else
                begin
                    state_next = crf_pkg::ST_HALTED;
                    count_next = '0;
                end
            end
            else
            begin
                result_next.event_ignored = 1'b1;
            end
        end
        else
        begin
            case (req_type)
                crf_pkg::REQ_START:
                begin
                    if (state_reg == crf_pkg::ST_HALTED)
                        do_init = 1'b1;
                    else
                        result_next.event_ignored = 1'b1;
                end
                crf_pkg::REQ_RECONNECT:
                begin
                    if (state_reg == crf_pkg::ST_HALTED)
                        do_init = 1'b1;
                    else if (state_reg == crf_pkg::ST_CONNECTING ||
                             state_reg == crf_pkg::ST_CONNECTED ||
                             state_reg == crf_pkg::ST_TIMEOUT)
                        do_fail = 1'b1;
                    else
                        result_next.event_ignored = 1'b1;
                end
                crf_pkg::REQ_INIT_REPLY:
                begin
                    if (state_reg == crf_pkg::ST_INIT)
                    begin
                        if (reply_ok)
                        begin
                            state_next = crf_pkg::ST_CONNECTING;
                            count_next = timer_load(connect_timeout_reg);
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    else
                    begin
                        result_next.event_ignored = 1'b1;
                    end
                end
                crf_pkg::REQ_OPEN_REPLY:
                begin
                    if (state_reg == crf_pkg::ST_CONNECTING)
                    begin
                        if (reply_ok)
                        begin
                            state_next = crf_pkg::ST_CONNECTED;
                            count_next = '0;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    else
                    begin
                        result_next.event_ignored = 1'b1;
                    end
                end
                crf_pkg::REQ_LINK_ERROR:
                begin
                    if (state_reg == crf_pkg::ST_CONNECTING)
                        do_fail = 1'b1;
                    else
                        result_next.event_ignored = 1'b1;
                end
                crf_pkg::REQ_TICK:
                begin
                    if (state_reg == crf_pkg::ST_CONNECTING)
                    begin
                        // expiry passes through timeout straight into a failure
                        if (expired)
                        begin
                            do_fail   = 1'b1;
                            fail_from = crf_pkg::LINK_TIMEOUT;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else if (state_reg == crf_pkg::ST_FAILED)
                    begin
                        if (expired)
                            do_init = 1'b1;
                        else
                            count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        result_next.event_ignored = 1'b1;
                    end
                end
                default:
                begin
                    result_next.event_ignored = 1'b1;
                end
            endcase
        end

        if (do_fail)
        begin
            result_next.request_close = 1'b1;
            origin_next = fail_from;
            state_next  = crf_pkg::ST_FAILED;
            count_next  = '0;
            if (hook_enable_reg)
            begin
                await_next = 1'b1;
                result_next.ask_hook = 1'b1;
            end
            else if (fail_from == crf_pkg::LINK_TIMEOUT)
            begin
                do_init = 1'b1;
            end
            else
            begin
                count_next = timer_load(retry_delay_reg);
            end
        end

        if (do_init)
        begin
            state_next = crf_pkg::ST_INIT;
            count_next = '0;
            result_next.request_init = 1'b1;
        end

        result_next.link_state = crf_pkg::state_code(state_next);
        result_next.fail_cause = origin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connect_timeout_reg <= crf_pkg::CONNECT_TIMEOUT_RST;
            retry_delay_reg     <= crf_pkg::RETRY_DELAY_RST;
            hook_enable_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crf_pkg::CFG_CONNECT_TIMEOUT: connect_timeout_reg <= cfg_data;
                crf_pkg::CFG_RETRY_DELAY:     retry_delay_reg     <= cfg_data;
                crf_pkg::CFG_HOOK_ENABLE:     hook_enable_reg     <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crf_pkg::ST_HALTED;
            origin_reg    <= crf_pkg::LINK_HALTED;
            count_reg     <= '0;
            await_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg  <= state_next;
                origin_reg <= origin_next;
                count_reg  <= count_next;
                await_reg  <= await_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, result_reg};

    // a hook request always comes with a close and leaves the link failed
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result_reg.ask_hook) |->
            (result_reg.request_close && result_reg.link_state == crf_pkg::LINK_FAILED))
        else $error("hook request without close in failed state");

    // an init request always reports the init state
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result_reg.request_init) |->
            (result_reg.link_state == crf_pkg::LINK_INIT))
        else $error("init request outside init state");

    // waiting for a hook decision only happens in failed
    assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> (state_reg == crf_pkg::ST_FAILED))
        else $error("awaiting decision outside failed state");

    // timeout is transient and never held
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != crf_pkg::ST_TIMEOUT)
        else $error("timeout state held");

    // a stalled result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(result_reg)))
        else $error("pending result lost or changed");

endmodule

/* tb/connection_retry_checker.sv */
// ----------------------------------------------------------------------------
// connection_retry_checker
// Watches the event, result and register channels of the connection retry
// state machine, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module connection_retry_checker #(
    parameter int TIMER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    // predicted link state and register copies
    logic [2:0]            link_q;
    logic [2:0]            fail_origin_q;
    logic [TIMER_BITS-1:0] ticks_left;
    logic                  hook_pending;
    logic [15:0]           connect_limit;
    logic [15:0]           retry_limit;
    logic                  hook_on;

    crf_pkg::result_t expected_results[$];
    crf_pkg::result_t want;
    crf_pkg::result_t got;

    // loads larger than the countdown can hold stick at its top value
    function automatic logic [TIMER_BITS-1:0] clamp_load(input logic [15:0] value);
        logic [32:0] top_value;
        logic [32:0] widened;
        top_value = (33'd1 << TIMER_BITS) - 33'd1;
        widened   = {17'd0, value};
        if (widened > top_value)
            return top_value[TIMER_BITS-1:0];
        return widened[TIMER_BITS-1:0];
    endfunction

    task automatic start_init(inout crf_pkg::result_t r);
        link_q         = crf_pkg::LINK_INIT;
        ticks_left     = '0;
        r.request_init = 1'b1;
    endtask

    task automatic drop_link(input logic [2:0] from, inout crf_pkg::result_t r);
        r.request_close = 1'b1;
        fail_origin_q   = from;
        link_q          = crf_pkg::LINK_FAILED;
        ticks_left      = '0;
        if (hook_on)
        begin
            hook_pending = 1'b1;
            r.ask_hook   = 1'b1;
        end
        else if (from == crf_pkg::LINK_TIMEOUT)
            start_init(r);
        else
            ticks_left = clamp_load(retry_limit);
    endtask

    task automatic predict_event(input logic [2:0] req, input logic ok,
                                 output crf_pkg::result_t r);
        logic ignored;
        r       = '0;
        ignored = 1'b0;
        if (hook_pending)
        begin
            // only the decision counts while the hook is being asked
            if (req == crf_pkg::REQ_HOOK)
            begin
                hook_pending = 1'b0;
                if (ok)
                    start_init(r);
                else
                begin
                    link_q     = crf_pkg::LINK_HALTED;
                    ticks_left = '0;
                end
            end
            else
                ignored = 1'b1;
        end
        else
        begin
            case (req)
                crf_pkg::REQ_START:
                    if (link_q == crf_pkg::LINK_HALTED)
                        start_init(r);
                    else
                        ignored = 1'b1;
                crf_pkg::REQ_RECONNECT:
                    if (link_q == crf_pkg::LINK_HALTED)
                        start_init(r);
                    else if (link_q == crf_pkg::LINK_CONNECTING ||
                             link_q == crf_pkg::LINK_CONNECTED ||
                             link_q == crf_pkg::LINK_TIMEOUT)
                        drop_link(link_q, r);
                    else
                        ignored = 1'b1;
                crf_pkg::REQ_INIT_REPLY:
                    if (link_q == crf_pkg::LINK_INIT)
                    begin
                        if (ok)
                        begin
                            link_q     = crf_pkg::LINK_CONNECTING;
                            ticks_left = clamp_load(connect_limit);
                        end
                        else
                            drop_link(crf_pkg::LINK_INIT, r);
                    end
                    else
                        ignored = 1'b1;
                crf_pkg::REQ_OPEN_REPLY:
                    if (link_q == crf_pkg::LINK_CONNECTING)
                    begin
                        if (ok)
                        begin
                            link_q     = crf_pkg::LINK_CONNECTED;
                            ticks_left = '0;
                        end
                        else
                            drop_link(crf_pkg::LINK_CONNECTING, r);
                    end
                    else
                        ignored = 1'b1;
                crf_pkg::REQ_LINK_ERROR:
                    if (link_q == crf_pkg::LINK_CONNECTING)
                        drop_link(crf_pkg::LINK_CONNECTING, r);
                    else
                        ignored = 1'b1;
                crf_pkg::REQ_TICK:
                    if (link_q == crf_pkg::LINK_CONNECTING)
                    begin
                        // expiry passes through timeout straight into a failure
                        if (ticks_left <= TIMER_BITS'(1))
                            drop_link(crf_pkg::LINK_TIMEOUT, r);
                        else
                            ticks_left = ticks_left - 1'b1;
                    end
                    else if (link_q == crf_pkg::LINK_FAILED)
                    begin
                        if (ticks_left <= TIMER_BITS'(1))
                            start_init(r);
                        else
                            ticks_left = ticks_left - 1'b1;
                    end
                    else
                        ignored = 1'b1;
                default:
                    ignored = 1'b1;
            endcase
        end
        r.link_state    = link_q;
        r.fail_cause    = fail_origin_q;
        r.event_ignored = ignored;
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_q        = crf_pkg::LINK_HALTED;
            fail_origin_q = '0;
            ticks_left    = '0;
            hook_pending  = 1'b0;
            connect_limit = crf_pkg::CONNECT_TIMEOUT_RST;
            retry_limit   = crf_pkg::RETRY_DELAY_RST;
            hook_on       = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    crf_pkg::CFG_CONNECT_TIMEOUT: connect_limit = cfg_data;
                    crf_pkg::CFG_RETRY_DELAY:     retry_limit   = cfg_data;
                    crf_pkg::CFG_HOOK_ENABLE:     hook_on       = cfg_data[0];
                    default:                      ;
                endcase
            end
            // results are registered before they leave, so check first
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    got  = m_tdata[9:0];
                    check_field("link_state", int'(want.link_state),
                                int'(got.link_state));
                    check_field("request_init", int'(want.request_init),
                                int'(got.request_init));
                    check_field("request_close", int'(want.request_close),
                                int'(got.request_close));
                    check_field("ask_hook", int'(want.ask_hook), int'(got.ask_hook));
                    check_field("fail_cause", int'(want.fail_cause),
                                int'(got.fail_cause));
                    check_field("event_ignored", int'(want.event_ignored),
                                int'(got.event_ignored));
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_event(s_tdata[2:0], s_tdata[3], want);
                expected_results.push_back(want);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

/* tb/tb_connection_retry_fsm.sv */
// ----------------------------------------------------------------------------
// tb_connection_retry_fsm
// Drives directed and random link events through the connection retry state
// machine under several register settings, with random gaps on both streams
// and one long output stall; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_connection_retry_fsm;

    localparam logic [2:0] REQ_RESERVED = 3'd7;
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;
    localparam int         HOLD_CYCLES  = 64;
    localparam int         CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    int   idle_max    = 7;
    int   stall_left  = 0;
    logic hold_start;
    logic hold_done   = 1'b0;

    connection_retry_fsm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    connection_retry_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stall after each transaction, one long hold-off
    always @(posedge clk)
    begin
        if (hold_start && !hold_done)
        begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        else if (m_tvalid && m_tready)
            stall_left = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
        else if (stall_left > 0)
            stall_left--;
        m_tready <= (stall_left == 0);
    end

    // handshakes are sampled at the falling edge, where nothing moves
    task automatic push_event(input logic [2:0] req, input logic ok);
        int gap;
        gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, ok, req};
        forever
        begin
            @(negedge clk);
            if (s_tready)
                break;
        end
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic await_idle();
        s_tvalid <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (outstanding == 0)
                break;
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic set_link_config(input logic [15:0] timeout, input logic [15:0] retry,
                                   input logic hook, input int idle);
        await_idle();
        idle_max <= idle;
        write_reg(crf_pkg::CFG_CONNECT_TIMEOUT, timeout);
        write_reg(crf_pkg::CFG_RETRY_DELAY, retry);
        write_reg(crf_pkg::CFG_HOOK_ENABLE, {15'd0, hook});
    endtask

    // weighted toward events that move the link forward
    task automatic run_random(input int count);
        int         pick;
        logic [2:0] req;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                req = crf_pkg::REQ_START;
            else if (pick < 14)
                req = crf_pkg::REQ_RECONNECT;
            else if (pick < 32)
                req = crf_pkg::REQ_INIT_REPLY;
            else if (pick < 48)
                req = crf_pkg::REQ_OPEN_REPLY;
            else if (pick < 53)
                req = crf_pkg::REQ_LINK_ERROR;
            else if (pick < 85)
                req = crf_pkg::REQ_TICK;
            else if (pick < 97)
                req = crf_pkg::REQ_HOOK;
            else
                req = REQ_RESERVED;
            push_event(req, $urandom_range(0, 3) != 0);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        hold_start = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: events that do not apply, then a slow connect attempt
        push_event(crf_pkg::REQ_TICK, 1'b0);
        push_event(crf_pkg::REQ_HOOK, 1'b1);
        push_event(REQ_RESERVED, 1'b1);
        push_event(crf_pkg::REQ_OPEN_REPLY, 1'b1);
        push_event(crf_pkg::REQ_START, 1'b1);
        push_event(crf_pkg::REQ_START, 1'b0);
        push_event(crf_pkg::REQ_INIT_REPLY, 1'b1);
        push_event(crf_pkg::REQ_TICK, 1'b1);

        await_idle();
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        set_link_config(16'd2, 16'd0, 1'b0, 7);
        push_event(crf_pkg::REQ_LINK_ERROR, 1'b0);
        push_event(crf_pkg::REQ_RECONNECT, 1'b1);
        push_event(crf_pkg::REQ_TICK, 1'b0);
        push_event(crf_pkg::REQ_INIT_REPLY, 1'b0);
        push_event(crf_pkg::REQ_TICK, 1'b0);
        push_event(crf_pkg::REQ_INIT_REPLY, 1'b1);
        push_event(crf_pkg::REQ_TICK, 1'b0);
        // countdown expires: timeout re-enters init at once
        push_event(crf_pkg::REQ_TICK, 1'b0);
        push_event(crf_pkg::REQ_INIT_REPLY, 1'b1);
        push_event(crf_pkg::REQ_OPEN_REPLY, 1'b0);
        push_event(crf_pkg::REQ_TICK, 1'b0);
        push_event(crf_pkg::REQ_INIT_REPLY, 1'b1);
        push_event(crf_pkg::REQ_OPEN_REPLY, 1'b1);
        push_event(crf_pkg::REQ_RECONNECT, 1'b0);

        await_idle();
        write_reg(crf_pkg::CFG_HOOK_ENABLE, 16'd1);
        push_event(crf_pkg::REQ_TICK, 1'b0);
        push_event(crf_pkg::REQ_INIT_REPLY, 1'b0);
        push_event(crf_pkg::REQ_TICK, 1'b1);
        push_event(crf_pkg::REQ_HOOK, 1'b1);
        push_event(crf_pkg::REQ_INIT_REPLY, 1'b0);
        // decision still obeyed once the hook is switched off
        await_idle();
        write_reg(crf_pkg::CFG_HOOK_ENABLE, 16'd0);
        push_event(crf_pkg::REQ_HOOK, 1'b0);
        push_event(crf_pkg::REQ_RECONNECT, 1'b1);

        set_link_config(16'd1, 16'd0, 1'b0, 7);
        run_random(115);

        // back to back events while the result side holds off
        set_link_config(16'd3, 16'd2, 1'b1, 0);
        hold_start <= 1'b1;
        run_random(115);

        set_link_config(16'd0, 16'd5, 1'b1, 7);
        run_random(115);

        repeat (2)
        begin
            set_link_config(16'($urandom_range(1, 6)), 16'($urandom_range(0, 6)),
                            1'($urandom_range(0, 1)),
                            ($urandom_range(0, 1) != 0) ? 7 : 0);
            run_random(115);
        end

        set_link_config(16'hFFFF, 16'hFFFF, 1'b1, 7);
        run_random(60);
        // longest retry delay without the hook parks the link in failed
        set_link_config(16'd4, 16'hFFFF, 1'b0, 7);
        run_random(55);

        await_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* connection_retry_fsm.f */
src/crf_pkg.sv
src/connection_retry_fsm.sv
tb/connection_retry_checker.sv
tb/tb_connection_retry_fsm.sv
